// ===== sv/msb_pkg.sv =====
// Shared types, register map and channel-scaling function for the span pixel blender.
`timescale 1ns / 1ps

package msb_pkg;

    localparam int ADDR_W = 5;

    // Register indexes (byte address is 4 * index)
    localparam logic [2:0] REG_FILL_RED      = 3'd0;
    localparam logic [2:0] REG_FILL_GREEN    = 3'd1;
    localparam logic [2:0] REG_FILL_BLUE     = 3'd2;
    localparam logic [2:0] REG_FILL_ALPHA    = 3'd3;
    localparam logic [2:0] REG_CHANNEL_ORDER = 3'd4;
    localparam logic [2:0] REG_MASK_MODE     = 3'd5;
    localparam logic [2:0] REG_SOURCE_SELECT = 3'd6;
    localparam logic [2:0] REG_GRADIENT_TRANS = 3'd7;

    localparam logic [1:0] MASK_NONE    = 2'd0;
    localparam logic [1:0] MASK_ALPHA   = 2'd1;
    localparam logic [1:0] MASK_INVERSE = 2'd2;

    localparam logic       ORDER_ARGB   = 1'b0;
    localparam logic       SRC_SOLID    = 1'b0;

    localparam logic [7:0] FULL_ALPHA   = 8'd255;

    typedef struct packed {
        logic [7:0] fill_red;
        logic [7:0] fill_green;
        logic [7:0] fill_blue;
        logic [7:0] fill_alpha;
        logic       channel_order;
        logic [1:0] mask_mode;
        logic       source_select;
        logic       gradient_translucent;
    } cfg_t;

    // Register values after reset: opaque black solid fill, no mask
    localparam cfg_t CFG_RESET = '{
        fill_red:             8'd0,
        fill_green:           8'd0,
        fill_blue:            8'd0,
        fill_alpha:           FULL_ALPHA,
        channel_order:        ORDER_ARGB,
        mask_mode:            MASK_NONE,
        source_select:        SRC_SOLID,
        gradient_translucent: 1'b0
    };

    // Per-pixel path selection, carried down the pipe with the data
    typedef struct packed {
        logic opaque;
        logic solid_mask;
        logic grad_mask;
        logic full_cov;
    } path_t;

    // Every byte lane c becomes (c * f) >> 8
    function automatic logic [31:0] scale_px(input logic [31:0] px, input logic [7:0] f);
        logic [31:0] res;
        logic [15:0] prod;
        res = '0;
        for (int i = 0; i < 4; i++) begin
            prod = px[8*i +: 8] * f;
            res[8*i +: 8] = prod[15:8];
        end
        return res;
    endfunction

endpackage

// ===== sv/msb_regs.sv =====
// APB-style configuration registers of the span pixel blender.
`timescale 1ns / 1ps

module msb_regs (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [msb_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready,
    output msb_pkg::cfg_t              cfg
);

    msb_pkg::cfg_t cfg_reg;
    msb_pkg::cfg_t cfg_next;
    logic          wr_en;
    logic [2:0]    idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = paddr[4:2];
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (idx)
                msb_pkg::REG_FILL_RED:       cfg_next.fill_red = pwdata[7:0];
                msb_pkg::REG_FILL_GREEN:     cfg_next.fill_green = pwdata[7:0];
                msb_pkg::REG_FILL_BLUE:      cfg_next.fill_blue = pwdata[7:0];
                msb_pkg::REG_FILL_ALPHA:     cfg_next.fill_alpha = pwdata[7:0];
                msb_pkg::REG_CHANNEL_ORDER:  cfg_next.channel_order = pwdata[0];
                msb_pkg::REG_MASK_MODE:      cfg_next.mask_mode = pwdata[1:0];
                msb_pkg::REG_SOURCE_SELECT:  cfg_next.source_select = pwdata[0];
                msb_pkg::REG_GRADIENT_TRANS: cfg_next.gradient_translucent = pwdata[0];
                default:                     cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= msb_pkg::CFG_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb
    begin
        prdata = '0;
        case (idx)
            msb_pkg::REG_FILL_RED:       prdata[7:0] = cfg_reg.fill_red;
            msb_pkg::REG_FILL_GREEN:     prdata[7:0] = cfg_reg.fill_green;
            msb_pkg::REG_FILL_BLUE:      prdata[7:0] = cfg_reg.fill_blue;
            msb_pkg::REG_FILL_ALPHA:     prdata[7:0] = cfg_reg.fill_alpha;
            msb_pkg::REG_CHANNEL_ORDER:  prdata[0]   = cfg_reg.channel_order;
            msb_pkg::REG_MASK_MODE:      prdata[1:0] = cfg_reg.mask_mode;
            msb_pkg::REG_SOURCE_SELECT:  prdata[0]   = cfg_reg.source_select;
            msb_pkg::REG_GRADIENT_TRANS: prdata[0]   = cfg_reg.gradient_translucent;
            default:                     prdata      = '0;
        endcase
    end

endmodule

// ===== sv/msb_source.sv =====
// First stage: builds the source pixel, the mask factor and the path flags.
`timescale 1ns / 1ps

module msb_source (
    input  logic                 clk,
    input  logic                 rst_n,
    input  msb_pkg::cfg_t        cfg,
    input  logic                 up_valid,
    output logic                 up_ready,
    input  logic [31:0]          dest_pixel,
    input  logic [31:0]          mask_pixel,
    input  logic [31:0]          gradient_pixel,
    input  logic [7:0]           coverage,
    output logic                 dn_valid,
    input  logic                 dn_ready,
    output logic [31:0]          src,
    output logic [31:0]          dst,
    output logic [7:0]           fac,
    output logic [7:0]           cov,
    output msb_pkg::path_t       path
);

    logic           valid_reg;
    logic           valid_next;
    logic [31:0]    src_reg;
    logic [31:0]    dst_reg;
    logic [7:0]     fac_reg;
    logic [7:0]     cov_reg;
    msb_pkg::path_t path_reg;

    logic [7:0]     r_pm;
    logic [7:0]     g_pm;
    logic [7:0]     b_pm;
    logic [16:0]    r_prod;
    logic [16:0]    g_prod;
    logic [16:0]    b_prod;
    logic           solid_trans;
    logic           masked;
    logic           translucent;
    logic           load;
    logic [31:0]    src_next;
    logic [7:0]     fac_next;
    msb_pkg::path_t path_next;

    always_comb
    begin
        solid_trans = (cfg.fill_alpha != msb_pkg::FULL_ALPHA);
        r_prod = 17'(cfg.fill_red * cfg.fill_alpha) + 17'd255;
        g_prod = 17'(cfg.fill_green * cfg.fill_alpha) + 17'd255;
        b_prod = 17'(cfg.fill_blue * cfg.fill_alpha) + 17'd255;
        r_pm = solid_trans ? r_prod[15:8] : cfg.fill_red;
        g_pm = solid_trans ? g_prod[15:8] : cfg.fill_green;
        b_pm = solid_trans ? b_prod[15:8] : cfg.fill_blue;

        masked = (cfg.mask_mode == msb_pkg::MASK_ALPHA) ||
                 (cfg.mask_mode == msb_pkg::MASK_INVERSE);
        fac_next = (cfg.mask_mode == msb_pkg::MASK_INVERSE) ? ~mask_pixel[31:24]
                                                            : mask_pixel[31:24];

        if (cfg.source_select == msb_pkg::SRC_SOLID)
        begin
            if (cfg.channel_order == msb_pkg::ORDER_ARGB)
                src_next = {cfg.fill_alpha, r_pm, g_pm, b_pm};
            else
                src_next = {cfg.fill_alpha, b_pm, g_pm, r_pm};
            translucent = solid_trans || masked;
        end
        else
        begin
            src_next    = gradient_pixel;
            translucent = cfg.gradient_translucent || masked;
        end

        path_next.opaque     = !translucent;
        path_next.solid_mask = masked && (cfg.source_select == msb_pkg::SRC_SOLID);
        path_next.grad_mask  = masked && (cfg.source_select != msb_pkg::SRC_SOLID);
        path_next.full_cov   = (coverage == msb_pkg::FULL_ALPHA);
    end

    assign up_ready   = !valid_reg || dn_ready;
    assign load       = up_ready && up_valid;
    assign valid_next = up_ready ? up_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            src_reg  <= src_next;
            dst_reg  <= dest_pixel;
            fac_reg  <= fac_next;
            cov_reg  <= coverage;
            path_reg <= path_next;
        end
    end

    assign dn_valid = valid_reg;
    assign src      = src_reg;
    assign dst      = dst_reg;
    assign fac      = fac_reg;
    assign cov      = cov_reg;
    assign path     = path_reg;

endmodule

// ===== sv/msb_mix.sv =====
// Second and third stages: coverage and mask scaling of the source, coverage lerp.
`timescale 1ns / 1ps

module msb_mix (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           up_valid,
    output logic           up_ready,
    input  logic [31:0]    src,
    input  logic [31:0]    dst,
    input  logic [7:0]     fac,
    input  logic [7:0]     cov,
    input  msb_pkg::path_t path,
    output logic           dn_valid,
    input  logic           dn_ready,
    output logic [31:0]    mixed,
    output logic [31:0]    dst_out,
    output logic           opaque
);

    // stage A
    logic           a_valid_reg;
    logic           a_valid_next;
    logic [31:0]    a_x_reg;
    logic [31:0]    a_dc_reg;
    logic [31:0]    a_dst_reg;
    logic [7:0]     a_fac_reg;
    logic [7:0]     a_cov_reg;
    msb_pkg::path_t a_path_reg;
    logic           a_ready;
    logic           a_bypass;
    logic [7:0]     a_k;
    logic [31:0]    a_x_next;

    // stage B
    logic           b_valid_reg;
    logic           b_valid_next;
    logic [31:0]    b_x_reg;
    logic [31:0]    b_dst_reg;
    logic           b_opaque_reg;
    logic           b_ready;
    logic [31:0]    b_x_next;

    // Gradient with mask scales by the mask first, everything else by coverage
    always_comb
    begin
        a_k      = path.grad_mask ? fac : cov;
        a_bypass = !path.grad_mask && path.full_cov;
        a_x_next = a_bypass ? src : msb_pkg::scale_px(src, a_k);
    end

    assign a_ready      = !a_valid_reg || b_ready;
    assign a_valid_next = a_ready ? up_valid : a_valid_reg;
    assign up_ready     = a_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            a_valid_reg <= 1'b0;
        else
            a_valid_reg <= a_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (a_ready && up_valid)
        begin
            a_x_reg    <= a_x_next;
            a_dc_reg   <= msb_pkg::scale_px(dst, ~cov);
            a_dst_reg  <= dst;
            a_fac_reg  <= fac;
            a_cov_reg  <= cov;
            a_path_reg <= path;
        end
    end

    always_comb
    begin
        if (a_path_reg.opaque)
            b_x_next = a_path_reg.full_cov ? a_x_reg : a_x_reg + a_dc_reg;
        else if (a_path_reg.solid_mask)
            b_x_next = msb_pkg::scale_px(a_x_reg, a_fac_reg);
        else if (a_path_reg.grad_mask && !a_path_reg.full_cov)
            b_x_next = msb_pkg::scale_px(a_x_reg, a_cov_reg) + a_dc_reg;
        else
            b_x_next = a_x_reg;
    end

    assign b_ready      = !b_valid_reg || dn_ready;
    assign b_valid_next = b_ready ? a_valid_reg : b_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            b_valid_reg <= 1'b0;
        else
            b_valid_reg <= b_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (b_ready && a_valid_reg)
        begin
            b_x_reg      <= b_x_next;
            b_dst_reg    <= a_dst_reg;
            b_opaque_reg <= a_path_reg.opaque;
        end
    end

    assign dn_valid = b_valid_reg;
    assign mixed    = b_x_reg;
    assign dst_out  = b_dst_reg;
    assign opaque   = b_opaque_reg;

endmodule

// ===== sv/msb_over.sv =====
// Last stage: source-over onto the destination, holds the output transfer.
`timescale 1ns / 1ps

module msb_over (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        up_valid,
    output logic        up_ready,
    input  logic [31:0] mixed,
    input  logic [31:0] dst,
    input  logic        opaque,
    output logic        dn_valid,
    input  logic        dn_ready,
    output logic [31:0] result
);

    logic        valid_reg;
    logic        valid_next;
    logic [31:0] res_reg;
    logic [31:0] res_next;

    // sums wrap at 32 bits, lanes carry into each other
    assign res_next   = opaque ? mixed
                               : mixed + msb_pkg::scale_px(dst, ~mixed[31:24]);
    assign up_ready   = !valid_reg || dn_ready;
    assign valid_next = up_ready ? up_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
            res_reg <= res_next;
    end

    assign dn_valid = valid_reg;
    assign result   = res_reg;

endmodule

// ===== sv/masked_span_pixel_blender.sv =====
// Top level of the masked span pixel blender.
//
//  channel  | direction | handshake          | payload
//  ---------+-----------+--------------------+-----------------------------------------
//  in       | sink      | in_valid/in_stall  | dest_pixel, mask_pixel, gradient_pixel,
//           |           |                    | coverage
//  out      | source    | out_valid/out_stall| blended_pixel
//  config   | sink      | APB psel/penable   | eight registers at 4*index
//
// Four register stages (source build, first scale, second scale/lerp, source-over);
// one pixel is taken every cycle while out_stall is low.
// Each stage loads whenever it is empty or the stage after it moves, so bubbles close up.
// A stall on the output holds the last stage and backs up stage by stage to in_stall.
// Reset clears the stage valid bits and sets the registers to their reset values.
`timescale 1ns / 1ps

module masked_span_pixel_blender (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [msb_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic [31:0]                dest_pixel,
    input  logic [31:0]                mask_pixel,
    input  logic [31:0]                gradient_pixel,
    input  logic [7:0]                 coverage,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic [31:0]                blended_pixel
);

    msb_pkg::cfg_t  cfg;
    logic           in_ready;
    logic           s1_valid;
    logic           s1_ready;
    logic [31:0]    s1_src;
    logic [31:0]    s1_dst;
    logic [7:0]     s1_fac;
    logic [7:0]     s1_cov;
    msb_pkg::path_t s1_path;
    logic           s3_valid;
    logic           s3_ready;
    logic [31:0]    s3_mixed;
    logic [31:0]    s3_dst;
    logic           s3_opaque;

    assign in_stall = !in_ready;

    msb_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    msb_source u_source (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg            (cfg),
        .up_valid       (in_valid),
        .up_ready       (in_ready),
        .dest_pixel     (dest_pixel),
        .mask_pixel     (mask_pixel),
        .gradient_pixel (gradient_pixel),
        .coverage       (coverage),
        .dn_valid       (s1_valid),
        .dn_ready       (s1_ready),
        .src            (s1_src),
        .dst            (s1_dst),
        .fac            (s1_fac),
        .cov            (s1_cov),
        .path           (s1_path)
    );

    msb_mix u_mix (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (s1_valid),
        .up_ready (s1_ready),
        .src      (s1_src),
        .dst      (s1_dst),
        .fac      (s1_fac),
        .cov      (s1_cov),
        .path     (s1_path),
        .dn_valid (s3_valid),
        .dn_ready (s3_ready),
        .mixed    (s3_mixed),
        .dst_out  (s3_dst),
        .opaque   (s3_opaque)
    );

    msb_over u_over (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (s3_valid),
        .up_ready (s3_ready),
        .mixed    (s3_mixed),
        .dst      (s3_dst),
        .opaque   (s3_opaque),
        .dn_valid (out_valid),
        .dn_ready (!out_stall),
        .result   (blended_pixel)
    );

endmodule
